[hw/rtl/ltsc_pkg.sv]
// Shared types, codes and constants of the line track status classifier.
package ltsc_pkg;

	// Fixed field widths
	localparam int SENSOR_W   = 12;
	localparam int POSITION_W = 14;
	localparam int MILEAGE_W  = 16;
	localparam int SHARP_W    = 14;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int OUT_W      = 32;

	// Default sensor count
	localparam int NUM_SENSORS_DEF = 5;

	// Position scale of the full array: each sensor pitch is this many counts
	localparam int POS_SCALE = 1000;

	// Line pattern levels, in percent of full scale
	localparam logic [6:0] PCT_LOW  = 7'd30;
	localparam logic [6:0] PCT_HIGH = 7'd70;
	localparam logic [6:0] PCT_BASE = 7'd100;

	// Register reset values
	localparam logic [11:0] FULL_SCALE_RST = 12'd1000;
	localparam logic [11:0] ON_TRACK_RST   = 12'd200;
	localparam logic [13:0] SHARP_RST      = 14'd834;
	localparam logic [15:0] MAX_LOST_RST   = 16'd200;

	// Register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_FULL_SCALE = 2'd0,
		CFG_ON_TRACK   = 2'd1,
		CFG_SHARP      = 2'd2,
		CFG_MAX_LOST   = 2'd3
	} cfg_index_t;

	// Track status codes
	typedef enum logic [3:0] {
		TS_NORMAL    = 4'd0,
		TS_LINE      = 4'd1,
		TS_SHARP_L   = 4'd2,
		TS_SHARP_R   = 4'd3,
		TS_TURN_L    = 4'd4,
		TS_TURN_R    = 4'd5,
		TS_GAP       = 4'd6,
		TS_MANOEUVRE = 4'd7,
		TS_FINISHED  = 4'd8
	} track_status_t;

	// Start/stop line history
	typedef enum logic [1:0] {
		LS_NONE  = 2'd0,
		LS_START = 2'd1,
		LS_STOP  = 2'd2
	} line_state_t;

	// Centroid sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ACC,
		PH_MUL,
		PH_DIV,
		PH_DONE
	} cen_phase_t;

	// Configuration registers
	typedef struct packed {
		logic [SENSOR_W-1:0]  full_scale;
		logic [SENSOR_W-1:0]  on_track;
		logic [SHARP_W-1:0]   sharp;
		logic [MILEAGE_W-1:0] max_lost;
	} cfg_t;

	// Centroid unit status
	typedef struct packed {
		logic idle;
		logic done;
		logic valid;
	} cen_stat_t;

	// One result item, lowest field in the lowest bits
	typedef struct packed {
		logic                  run_finished;
		logic                  abort_stop;
		logic                  lost_end;
		logic                  lost_begin;
		logic                  lap_stop;
		logic                  lap_start;
		logic                  allow_reverse;
		logic [POSITION_W-1:0] steer_position;
		track_status_t         track_status;
	} result_t;

endpackage

[hw/rtl/line_track_status_classifier_core.sv]
// Top level of the line track status classifier: ports, registers and item flow.
//
// Each accepted item is one line sensor sample; one result item comes back per sample,
// carrying the track status, the steering position and the lap, lost and abort events.
// An item keeps s_tready low from acceptance until its result is handed on, so the next
// item is taken only after the last one has gone through every step: the weighted sum is
// formed one inner sensor per cycle, then scaled by full scale, then the restoring divider
// forms the inner centroid one quotient bit per cycle, and last the result is handed to
// the output register. The result waits there, so the next item is taken while the last
// one is still unread; the status only advances once that register is free. Configuration
// writes go through cfg_we, cfg_addr and cfg_wdata and are to be made while no item is
// in flight.
module line_track_status_classifier_core #(
	parameter int NUM_SENSORS = ltsc_pkg::NUM_SENSORS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// start_run
	input  logic                                    s_tuser,
	// line_position, sensor_0 .. sensor_N-1, lost_mileage, observation_timeout, zero fill
	input  logic [((31 + 12 * NUM_SENSORS + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// track_status, steer_position, allow_reverse, lap_start, lap_stop, lost_begin,
	// lost_end, abort_stop, run_finished, zero fill
	output logic [ltsc_pkg::OUT_W-1:0]              m_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	input  logic                                    cfg_we,
	input  logic [ltsc_pkg::CFG_ADDR_W-1:0]         cfg_addr,
	input  logic [ltsc_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

	localparam int SNW    = ltsc_pkg::SENSOR_W;
	localparam int PW     = ltsc_pkg::POSITION_W;
	localparam int MW     = ltsc_pkg::MILEAGE_W;
	localparam int SENS0  = PW;
	localparam int MIL0   = PW + SNW * NUM_SENSORS;
	localparam int TMO0   = MIL0 + MW;
	localparam int QW     = $clog2(((1 << SNW) - 1) * (NUM_SENSORS - 2) + 1);

	ltsc_pkg::cfg_t      cfg_q;
	ltsc_pkg::cen_stat_t cen_stat;
	ltsc_pkg::result_t   res, res_q;

	logic                               start_run_q;
	logic [PW-1:0]                      line_position_q;
	logic [NUM_SENSORS-1:0][SNW-1:0]    sens_q;
	logic [MW-1:0]                      lost_mileage_q;
	logic                               timeout_q;
	logic [QW-1:0]                      pos3;
	logic                               accept;
	logic                               commit;
	logic                               m_tvalid_q;

	assign s_tready = cen_stat.idle;
	assign accept   = s_tvalid && s_tready;
	assign commit   = cen_stat.done && (!m_tvalid_q || m_tready);

	// Write the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_scale <= ltsc_pkg::FULL_SCALE_RST;
			cfg_q.on_track   <= ltsc_pkg::ON_TRACK_RST;
			cfg_q.sharp      <= ltsc_pkg::SHARP_RST;
			cfg_q.max_lost   <= ltsc_pkg::MAX_LOST_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				ltsc_pkg::CFG_FULL_SCALE: cfg_q.full_scale <= cfg_wdata[SNW-1:0];
				ltsc_pkg::CFG_ON_TRACK:   cfg_q.on_track   <= cfg_wdata[SNW-1:0];
				ltsc_pkg::CFG_SHARP:      cfg_q.sharp      <= cfg_wdata[ltsc_pkg::SHARP_W-1:0];
				ltsc_pkg::CFG_MAX_LOST:   cfg_q.max_lost   <= cfg_wdata[MW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Capture the input item
	always_ff @(posedge clk) begin
		if (accept) begin
			start_run_q     <= s_tuser;
			line_position_q <= s_tdata[SENS0-1:0];
			for (int i = 0; i < NUM_SENSORS; i++) begin
				sens_q[i] <= s_tdata[SENS0 + SNW * i +: SNW];
			end
			lost_mileage_q  <= s_tdata[MIL0 +: MW];
			timeout_q       <= s_tdata[TMO0];
		end
	end

	ltsc_centroid #(
		.NUM_SENSORS (NUM_SENSORS),
		.QW          (QW)
	) u_centroid (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.ack        (commit),
		.full_scale (cfg_q.full_scale),
		.sens       (sens_q),
		.pos3       (pos3),
		.stat       (cen_stat)
	);

	ltsc_classify #(
		.NUM_SENSORS (NUM_SENSORS),
		.QW          (QW)
	) u_classify (
		.clk                 (clk),
		.arst_n              (arst_n),
		.commit              (commit),
		.cfg                 (cfg_q),
		.start_run           (start_run_q),
		.line_position       (line_position_q),
		.sens                (sens_q),
		.lost_mileage        (lost_mileage_q),
		.observation_timeout (timeout_q),
		.pos3                (pos3),
		.pos3_valid          (cen_stat.valid),
		.res                 (res)
	);

	// Hold the result item until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) res_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = ltsc_pkg::OUT_W'(res_q);

endmodule

[hw/rtl/ltsc_centroid.sv]
// Inner sensor centroid: weighted sum sequencer and restoring divider.
module ltsc_centroid #(
	parameter int NUM_SENSORS = ltsc_pkg::NUM_SENSORS_DEF,
	parameter int QW = 14
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           start,
	input  logic                                           ack,
	input  logic [ltsc_pkg::SENSOR_W-1:0]                  full_scale,
	input  logic [NUM_SENSORS-1:0][ltsc_pkg::SENSOR_W-1:0] sens,
	output logic [QW-1:0]                                  pos3,
	output ltsc_pkg::cen_stat_t                            stat
);

	localparam int IW    = $clog2(NUM_SENSORS);
	localparam int WMAX  = ((1 << ltsc_pkg::SENSOR_W) - 1) * (NUM_SENSORS - 2)
		* (NUM_SENSORS - 1) / 2;
	localparam int WW    = $clog2(WMAX + 1);
	localparam int NUMW  = WW + ltsc_pkg::SENSOR_W;
	localparam int DW    = QW;
	localparam int SHW   = DW + QW - 1;
	localparam int CW    = (NUMW > SHW) ? NUMW : SHW;
	localparam int CNTW  = $clog2(QW);

	ltsc_pkg::cen_phase_t phase_q, phase_d;

	logic [IW-1:0]   idx_q;
	logic [WW-1:0]   w_q;
	logic [DW-1:0]   den_q;
	logic [CW-1:0]   rem_q;
	logic [CW-1:0]   dsh_q;
	logic [QW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;

	logic            last_idx;
	logic            last_bit;
	logic            ge;
	logic [NUMW-1:0] num;

	assign last_idx = (idx_q == IW'(NUM_SENSORS - 2));
	assign last_bit = (cnt_q == '0);
	assign ge       = (rem_q >= dsh_q);
	assign num      = NUMW'(full_scale) * NUMW'(w_q);

	// Hold the phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ltsc_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Sequence the phases
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			ltsc_pkg::PH_IDLE: if (start) phase_d = ltsc_pkg::PH_ACC;
			ltsc_pkg::PH_ACC:  if (last_idx) phase_d = ltsc_pkg::PH_MUL;
			ltsc_pkg::PH_MUL:  phase_d = ltsc_pkg::PH_DIV;
			ltsc_pkg::PH_DIV:  if (last_bit) phase_d = ltsc_pkg::PH_DONE;
			ltsc_pkg::PH_DONE: if (ack) phase_d = ltsc_pkg::PH_IDLE;
			default:           phase_d = ltsc_pkg::PH_IDLE;
		endcase
	end

	// Accumulate, scale and divide, one step per cycle
	always_ff @(posedge clk) begin
		case (phase_q)
			ltsc_pkg::PH_IDLE: begin
				idx_q <= IW'(1);
				w_q   <= '0;
				den_q <= '0;
			end
			ltsc_pkg::PH_ACC: begin
				w_q   <= w_q + WW'(idx_q) * WW'(sens[idx_q]);
				den_q <= den_q + DW'(sens[idx_q]);
				idx_q <= idx_q + IW'(1);
			end
			ltsc_pkg::PH_MUL: begin
				rem_q <= CW'(num);
				dsh_q <= CW'({den_q, {(QW-1){1'b0}}});
				quo_q <= '0;
				cnt_q <= CNTW'(QW - 1);
			end
			ltsc_pkg::PH_DIV: begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[QW-2:0], ge};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - CNTW'(1);
			end
			default: begin
			end
		endcase
	end

	assign pos3       = quo_q;
	assign stat.idle  = (phase_q == ltsc_pkg::PH_IDLE);
	assign stat.done  = (phase_q == ltsc_pkg::PH_DONE);
	assign stat.valid = (den_q != '0);

endmodule

[hw/rtl/ltsc_classify.sv]
// Track status classifier: line and gap detection, status and event pulses.
module ltsc_classify #(
	parameter int NUM_SENSORS = ltsc_pkg::NUM_SENSORS_DEF,
	parameter int QW = 14
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           commit,
	input  ltsc_pkg::cfg_t                                 cfg,
	input  logic                                           start_run,
	input  logic [ltsc_pkg::POSITION_W-1:0]                line_position,
	input  logic [NUM_SENSORS-1:0][ltsc_pkg::SENSOR_W-1:0] sens,
	input  logic [ltsc_pkg::MILEAGE_W-1:0]                 lost_mileage,
	input  logic                                           observation_timeout,
	input  logic [QW-1:0]                                  pos3,
	input  logic                                           pos3_valid,
	output ltsc_pkg::result_t                              res
);

	localparam int SW      = QW + 2;
	localparam int MID     = NUM_SENSORS / 2;
	localparam int RIGHT   = NUM_SENSORS - 1;
	localparam int POS_MAX = (NUM_SENSORS - 1) * ltsc_pkg::POS_SCALE;

	ltsc_pkg::track_status_t ts_q, cur_ts, next_ts, final_ts;
	ltsc_pkg::line_state_t   ls_q, cur_ls, next_ls;
	logic [ltsc_pkg::POSITION_W-1:0] prev_q;

	logic signed [SW-1:0] full_s, half_s, sp_s, mid_lo, mid_hi, gap_lo, gap_hi;
	logic signed [SW-1:0] pos_s, pos3_s, diff_s, thr_s, neg_thr, prev_s, pos_o;
	logic signed [SW-1:0] pos_max_s;
	logic                 gap, line_pat, pos3_mid, pos_mid;
	logic                 rev, lap_start, lap_stop, lost_begin, lost_end, ab;
	logic                 was_lost, now_lost;

	// True when s is at least pct percent of full, rounded down
	function automatic logic at_least_pct(
		input logic [ltsc_pkg::SENSOR_W-1:0] s,
		input logic [ltsc_pkg::SENSOR_W-1:0] full,
		input logic [6:0]                    pct
	);
		logic [19:0] lhs;
		logic [19:0] rhs;
		lhs = 20'(ltsc_pkg::PCT_BASE) * (20'(s) + 20'd1);
		rhs = 20'(pct) * 20'(full);
		return lhs > rhs;
	endfunction

	// Derive the thresholds from full scale
	always_comb begin
		full_s    = SW'(cfg.full_scale);
		half_s    = SW'(cfg.full_scale >> 1);
		sp_s      = SW'((32'(cfg.full_scale) * (NUM_SENSORS - 1)) >> 1);
		mid_lo    = sp_s - half_s;
		mid_hi    = sp_s + half_s;
		gap_lo    = sp_s - full_s;
		gap_hi    = sp_s + full_s;
		pos_max_s = SW'(POS_MAX);
		thr_s     = SW'(cfg.sharp);
		neg_thr   = -thr_s;
	end

	// Compare the positions and scan the sensors
	always_comb begin
		pos_s    = SW'(line_position);
		prev_s   = SW'(prev_q);
		pos3_s   = pos3_valid ? SW'(pos3) : '0;
		diff_s   = pos3_valid ? (pos_s - pos3_s) : '0;
		pos3_mid = (pos3_s >= mid_lo) && (pos3_s <= mid_hi);
		pos_mid  = (pos_s >= mid_lo) && (pos_s <= mid_hi);
		gap = 1'b1;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (sens[i] >= cfg.on_track) gap = 1'b0;
		end
		line_pat = at_least_pct(sens[0], cfg.full_scale, ltsc_pkg::PCT_LOW)
			&& !at_least_pct(sens[MID-1], cfg.full_scale, ltsc_pkg::PCT_HIGH)
			&& at_least_pct(sens[MID], cfg.full_scale, ltsc_pkg::PCT_HIGH)
			&& !at_least_pct(sens[MID+1], cfg.full_scale, ltsc_pkg::PCT_HIGH)
			&& at_least_pct(sens[RIGHT], cfg.full_scale, ltsc_pkg::PCT_LOW);
	end

	// Step the track status
	always_comb begin
		cur_ts    = start_run ? ltsc_pkg::TS_NORMAL : ts_q;
		cur_ls    = start_run ? ltsc_pkg::LS_NONE : ls_q;
		next_ts   = cur_ts;
		next_ls   = cur_ls;
		pos_o     = pos_s;
		rev       = 1'b1;
		lap_start = 1'b0;
		lap_stop  = 1'b0;
		if (cur_ts == ltsc_pkg::TS_LINE) begin
			if (pos_mid && (sens[0] < cfg.on_track) && (sens[RIGHT] < cfg.on_track))
				next_ts = ltsc_pkg::TS_NORMAL;
			rev = 1'b0;
		end else if (line_pat) begin
			if (cur_ls == ltsc_pkg::LS_NONE) begin
				lap_start = 1'b1;
				next_ls   = ltsc_pkg::LS_START;
				next_ts   = ltsc_pkg::TS_LINE;
			end else begin
				lap_stop = 1'b1;
				next_ls  = ltsc_pkg::LS_STOP;
				next_ts  = ltsc_pkg::TS_FINISHED;
			end
			rev = 1'b0;
		end else if (cur_ts == ltsc_pkg::TS_SHARP_L) begin
			if (pos3_s > mid_hi) begin
				next_ts = ltsc_pkg::TS_TURN_L;
				pos_o   = '0;
			end else begin
				pos_o = pos3_s;
			end
		end else if (cur_ts == ltsc_pkg::TS_SHARP_R) begin
			if (pos3_s < mid_lo) begin
				next_ts = ltsc_pkg::TS_TURN_R;
				pos_o   = pos_max_s;
			end else begin
				pos_o = pos3_s;
			end
		end else if (cur_ts == ltsc_pkg::TS_TURN_L) begin
			if (pos3_mid) next_ts = ltsc_pkg::TS_NORMAL;
			else pos_o = '0;
		end else if (cur_ts == ltsc_pkg::TS_TURN_R) begin
			if (pos3_mid) next_ts = ltsc_pkg::TS_NORMAL;
			else pos_o = pos_max_s;
		end else if ((diff_s <= neg_thr) && pos3_mid) begin
			next_ts = ltsc_pkg::TS_SHARP_L;
			pos_o   = pos3_s;
		end else if ((diff_s >= thr_s) && pos3_mid) begin
			next_ts = ltsc_pkg::TS_SHARP_R;
			pos_o   = pos3_s;
		end else if (gap) begin
			if ((prev_s >= gap_lo) && (prev_s < gap_hi)) begin
				pos_o   = sp_s;
				rev     = 1'b0;
				next_ts = ltsc_pkg::TS_GAP;
			end else begin
				next_ts = ltsc_pkg::TS_MANOEUVRE;
			end
		end else begin
			next_ts = ltsc_pkg::TS_NORMAL;
		end
	end

	// Raise the lost, found and abort events
	always_comb begin
		was_lost   = (cur_ts == ltsc_pkg::TS_GAP) || (cur_ts == ltsc_pkg::TS_MANOEUVRE);
		now_lost   = (next_ts == ltsc_pkg::TS_GAP) || (next_ts == ltsc_pkg::TS_MANOEUVRE);
		lost_begin = !was_lost && now_lost;
		lost_end   = was_lost && !now_lost;
		ab = (now_lost && (lost_mileage > cfg.max_lost))
			|| ((next_ts != ltsc_pkg::TS_FINISHED) && observation_timeout);
		final_ts = ab ? ltsc_pkg::TS_FINISHED : next_ts;
	end

	// Assemble the result item
	always_comb begin
		res.track_status   = final_ts;
		res.steer_position = pos_o[ltsc_pkg::POSITION_W-1:0];
		res.allow_reverse  = rev;
		res.lap_start      = lap_start;
		res.lap_stop       = lap_stop;
		res.lost_begin     = lost_begin;
		res.lost_end       = lost_end;
		res.abort_stop     = ab;
		res.run_finished   = (final_ts == ltsc_pkg::TS_FINISHED);
	end

	// Advance the status when the item commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q   <= ltsc_pkg::TS_NORMAL;
			ls_q   <= ltsc_pkg::LS_NONE;
			prev_q <= '0;
		end else if (commit) begin
			ts_q   <= final_ts;
			ls_q   <= next_ls;
			prev_q <= pos_o[ltsc_pkg::POSITION_W-1:0];
		end
	end

endmodule

[verif/line_track_status_classifier_core_test.sv]
// Self-checking testbench for the line track status classifier core.
module line_track_status_classifier_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NS          = ltsc_pkg::NUM_SENSORS_DEF;
	localparam int IN_W        = ((31 + 12 * NS + 7) / 8) * 8;
	localparam int RES_W       = $bits(ltsc_pkg::result_t);
	localparam int POS_LIMIT   = (1 << ltsc_pkg::POSITION_W) - 1;
	localparam int DRAIN_WAIT  = 30;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTING_ITEMS = 55;

	// One sensor sample, packed as it travels in s_tdata (lowest field first)
	typedef struct packed {
		logic                                  timeout;
		logic [ltsc_pkg::MILEAGE_W-1:0]        mileage;
		logic [NS-1:0][ltsc_pkg::SENSOR_W-1:0] sens;
		logic [ltsc_pkg::POSITION_W-1:0]       pos;
	} line_sample_t;

	// Shapes of generated samples
	typedef enum int {
		SK_CENTER,
		SK_SHARP_L,
		SK_SHARP_R,
		SK_INNER_L,
		SK_INNER_R,
		SK_LINE,
		SK_GAP,
		SK_OFF_LEFT,
		SK_NOISE
	} sample_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tuser = 1'b0;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [ltsc_pkg::OUT_W-1:0] m_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic cfg_we = 1'b0;
	logic [ltsc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [ltsc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	// Register copies
	logic [ltsc_pkg::SENSOR_W-1:0]  full_scale_r = ltsc_pkg::FULL_SCALE_RST;
	logic [ltsc_pkg::SENSOR_W-1:0]  on_track_r   = ltsc_pkg::ON_TRACK_RST;
	logic [ltsc_pkg::SHARP_W-1:0]   sharp_r      = ltsc_pkg::SHARP_RST;
	logic [ltsc_pkg::MILEAGE_W-1:0] max_lost_r   = ltsc_pkg::MAX_LOST_RST;

	// Classifier state copies
	ltsc_pkg::track_status_t         status_now = ltsc_pkg::TS_NORMAL;
	ltsc_pkg::line_state_t           line_hist  = ltsc_pkg::LS_NONE;
	logic [ltsc_pkg::POSITION_W-1:0] last_steer = '0;

	ltsc_pkg::result_t expected_q[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int settings_done = 0;
	int cycle_count = 0;

	line_track_status_classifier_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// End the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending", cycle_count,
				expected_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic bit is_lost_status(ltsc_pkg::track_status_t st);
		return (st == ltsc_pkg::TS_GAP) || (st == ltsc_pkg::TS_MANOEUVRE);
	endfunction

	function automatic int pick(int lo, int hi);
		if (hi <= lo)
			return lo;
		return lo + int'($urandom_range(hi - lo));
	endfunction

	// Advance the classifier copy by one sample and return the result it yields
	function automatic ltsc_pkg::result_t classify_sample(logic start, line_sample_t smp);
		ltsc_pkg::result_t res;
		int full, sp, mid_lo, mid_hi, pos_max, thr, pos, pos3, diff, lo_lvl, hi_lvl, prev;
		longint num, den;
		bit gap, reverse, abort;
		ltsc_pkg::track_status_t nxt;
		int mid;
		res = '0;
		reverse = 1'b1;
		mid = NS / 2;
		if (start) begin
			status_now = ltsc_pkg::TS_NORMAL;
			line_hist = ltsc_pkg::LS_NONE;
		end
		pos = int'(smp.pos);
		full = int'(full_scale_r);
		sp = (full * (NS - 1)) / 2;
		mid_lo = sp - full / 2;
		mid_hi = sp + full / 2;
		pos_max = (NS - 1) * ltsc_pkg::POS_SCALE;
		thr = int'(sharp_r);
		lo_lvl = (full * int'(ltsc_pkg::PCT_LOW)) / int'(ltsc_pkg::PCT_BASE);
		hi_lvl = (full * int'(ltsc_pkg::PCT_HIGH)) / int'(ltsc_pkg::PCT_BASE);

		// Inner centroid; all-zero inner sensors leave it at zero
		num = 0;
		den = 0;
		for (int i = 1; i < NS - 1; i++) begin
			num += longint'(i) * full * int'(smp.sens[i]);
			den += int'(smp.sens[i]);
		end
		pos3 = 0;
		diff = 0;
		if (den != 0) begin
			pos3 = int'(num / den);
			diff = pos - pos3;
		end

		gap = 1'b1;
		for (int i = 0; i < NS; i++)
			if (int'(smp.sens[i]) >= int'(on_track_r))
				gap = 1'b0;

		nxt = status_now;
		if (status_now == ltsc_pkg::TS_LINE) begin
			if (pos >= mid_lo && pos <= mid_hi && int'(smp.sens[0]) < int'(on_track_r) &&
				int'(smp.sens[NS-1]) < int'(on_track_r))
				nxt = ltsc_pkg::TS_NORMAL;
			reverse = 1'b0;
		end else if (int'(smp.sens[0]) >= lo_lvl && int'(smp.sens[mid-1]) < hi_lvl &&
			int'(smp.sens[mid]) >= hi_lvl && int'(smp.sens[mid+1]) < hi_lvl &&
			int'(smp.sens[NS-1]) >= lo_lvl) begin
			if (line_hist == ltsc_pkg::LS_NONE) begin
				res.lap_start = 1'b1;
				line_hist = ltsc_pkg::LS_START;
				nxt = ltsc_pkg::TS_LINE;
			end else begin
				res.lap_stop = 1'b1;
				line_hist = ltsc_pkg::LS_STOP;
				nxt = ltsc_pkg::TS_FINISHED;
			end
			reverse = 1'b0;
		end else if (status_now == ltsc_pkg::TS_SHARP_L) begin
			if (pos3 > mid_hi) begin
				nxt = ltsc_pkg::TS_TURN_L;
				pos = 0;
			end else begin
				pos = pos3;
			end
		end else if (status_now == ltsc_pkg::TS_SHARP_R) begin
			if (pos3 < mid_lo) begin
				nxt = ltsc_pkg::TS_TURN_R;
				pos = pos_max;
			end else begin
				pos = pos3;
			end
		end else if (status_now == ltsc_pkg::TS_TURN_L) begin
			if (pos3 >= mid_lo && pos3 <= mid_hi)
				nxt = ltsc_pkg::TS_NORMAL;
			else
				pos = 0;
		end else if (status_now == ltsc_pkg::TS_TURN_R) begin
			if (pos3 >= mid_lo && pos3 <= mid_hi)
				nxt = ltsc_pkg::TS_NORMAL;
			else
				pos = pos_max;
		end else if (diff <= -thr && pos3 >= mid_lo && pos3 <= mid_hi) begin
			nxt = ltsc_pkg::TS_SHARP_L;
			pos = pos3;
		end else if (diff >= thr && pos3 >= mid_lo && pos3 <= mid_hi) begin
			nxt = ltsc_pkg::TS_SHARP_R;
			pos = pos3;
		end else if (gap) begin
			prev = int'(last_steer);
			if (prev >= sp - full && prev < sp + full) begin
				pos = sp;
				reverse = 1'b0;
				nxt = ltsc_pkg::TS_GAP;
			end else begin
				nxt = ltsc_pkg::TS_MANOEUVRE;
			end
		end else begin
			nxt = ltsc_pkg::TS_NORMAL;
		end

		last_steer = pos[ltsc_pkg::POSITION_W-1:0];

		if (!is_lost_status(status_now) && is_lost_status(nxt))
			res.lost_begin = 1'b1;
		else if (is_lost_status(status_now) && !is_lost_status(nxt))
			res.lost_end = 1'b1;
		status_now = nxt;

		// Alarm abort on lost distance or observation timeout
		abort = 1'b0;
		if (is_lost_status(status_now) && smp.mileage > max_lost_r)
			abort = 1'b1;
		if (status_now != ltsc_pkg::TS_FINISHED && smp.timeout)
			abort = 1'b1;
		if (abort) begin
			res.abort_stop = 1'b1;
			status_now = ltsc_pkg::TS_FINISHED;
		end

		res.track_status = status_now;
		res.steer_position = last_steer;
		res.allow_reverse = reverse;
		res.run_finished = (status_now == ltsc_pkg::TS_FINISHED);
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
		mismatches++;
	endtask

	// Compare one result item against the oldest expectation
	task automatic check_result(ltsc_pkg::result_t got);
		ltsc_pkg::result_t want;
		if (expected_q.size() == 0) begin
			report_mismatch("unexpected item, track_status", int'(got.track_status), -1);
			results_seen++;
			return;
		end
		want = expected_q.pop_front();
		if (got.track_status !== want.track_status)
			report_mismatch("track_status", int'(got.track_status), int'(want.track_status));
		if (got.steer_position !== want.steer_position)
			report_mismatch("steer_position", int'(got.steer_position),
				int'(want.steer_position));
		if (got.allow_reverse !== want.allow_reverse)
			report_mismatch("allow_reverse", int'(got.allow_reverse), int'(want.allow_reverse));
		if (got.lap_start !== want.lap_start)
			report_mismatch("lap_start", int'(got.lap_start), int'(want.lap_start));
		if (got.lap_stop !== want.lap_stop)
			report_mismatch("lap_stop", int'(got.lap_stop), int'(want.lap_stop));
		if (got.lost_begin !== want.lost_begin)
			report_mismatch("lost_begin", int'(got.lost_begin), int'(want.lost_begin));
		if (got.lost_end !== want.lost_end)
			report_mismatch("lost_end", int'(got.lost_end), int'(want.lost_end));
		if (got.abort_stop !== want.abort_stop)
			report_mismatch("abort_stop", int'(got.abort_stop), int'(want.abort_stop));
		if (got.run_finished !== want.run_finished)
			report_mismatch("run_finished", int'(got.run_finished), int'(want.run_finished));
		results_seen++;
	endtask

	// Take result items and stall the output at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(ltsc_pkg::result_t'(m_tdata[RES_W-1:0]));
			m_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
		end
	end

	// Offer one item, wait for acceptance, then idle at random
	task automatic send_sample(logic start, line_sample_t smp);
		s_tuser <= start;
		s_tdata <= IN_W'(smp);
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		expected_q.push_back(classify_sample(start, smp));
		items_sent++;
		if (int'($urandom_range(99)) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while (int'($urandom_range(99)) < send_idle_pct);
		end
	endtask

	// Hold off the sender until every result is in and the core is idle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_register(ltsc_pkg::cfg_index_t idx,
		logic [ltsc_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ltsc_pkg::CFG_FULL_SCALE: full_scale_r = val[ltsc_pkg::SENSOR_W-1:0];
			ltsc_pkg::CFG_ON_TRACK:   on_track_r = val[ltsc_pkg::SENSOR_W-1:0];
			ltsc_pkg::CFG_SHARP:      sharp_r = val[ltsc_pkg::SHARP_W-1:0];
			ltsc_pkg::CFG_MAX_LOST:   max_lost_r = val[ltsc_pkg::MILEAGE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Write all registers: reset values, all high, all low, zero full scale or random
	task automatic apply_setting(int sel);
		int full;
		wait_drained();
		full = pick(100, 4095);
		case (sel)
			0: begin
				write_register(ltsc_pkg::CFG_FULL_SCALE, 16'(ltsc_pkg::FULL_SCALE_RST));
				write_register(ltsc_pkg::CFG_ON_TRACK, 16'(ltsc_pkg::ON_TRACK_RST));
				write_register(ltsc_pkg::CFG_SHARP, 16'(ltsc_pkg::SHARP_RST));
				write_register(ltsc_pkg::CFG_MAX_LOST, ltsc_pkg::MAX_LOST_RST);
			end
			1: begin
				write_register(ltsc_pkg::CFG_FULL_SCALE, 16'(4095));
				write_register(ltsc_pkg::CFG_ON_TRACK, 16'(4095));
				write_register(ltsc_pkg::CFG_SHARP, 16'(16383));
				write_register(ltsc_pkg::CFG_MAX_LOST, 16'(65535));
			end
			2: begin
				write_register(ltsc_pkg::CFG_FULL_SCALE, 16'(1));
				write_register(ltsc_pkg::CFG_ON_TRACK, 16'(0));
				write_register(ltsc_pkg::CFG_SHARP, 16'(0));
				write_register(ltsc_pkg::CFG_MAX_LOST, 16'(0));
			end
			3: begin
				write_register(ltsc_pkg::CFG_FULL_SCALE, 16'(0));
				write_register(ltsc_pkg::CFG_ON_TRACK, 16'(pick(0, 300)));
				write_register(ltsc_pkg::CFG_SHARP, 16'(pick(0, 1000)));
				write_register(ltsc_pkg::CFG_MAX_LOST, 16'(pick(0, 400)));
			end
			default: begin
				write_register(ltsc_pkg::CFG_FULL_SCALE, 16'(full));
				write_register(ltsc_pkg::CFG_ON_TRACK, 16'(pick(0, full / 2)));
				write_register(ltsc_pkg::CFG_SHARP, 16'(pick(0, 2 * full)));
				write_register(ltsc_pkg::CFG_MAX_LOST, 16'(pick(0, 400)));
			end
		endcase
		settings_done++;
	endtask

	function automatic line_sample_t sample_of(int pos, int s0, int s1, int s2, int s3,
		int s4, int mileage, bit timeout);
		line_sample_t smp;
		smp.pos = ltsc_pkg::POSITION_W'(pos);
		smp.sens[0] = ltsc_pkg::SENSOR_W'(s0);
		smp.sens[1] = ltsc_pkg::SENSOR_W'(s1);
		smp.sens[2] = ltsc_pkg::SENSOR_W'(s2);
		smp.sens[3] = ltsc_pkg::SENSOR_W'(s3);
		smp.sens[4] = ltsc_pkg::SENSOR_W'(s4);
		smp.mileage = ltsc_pkg::MILEAGE_W'(mileage);
		smp.timeout = timeout;
		return smp;
	endfunction

	// Build a random sample of the given shape around the current registers
	function automatic line_sample_t make_sample(sample_kind_t kind);
		int full, sp, below, lo_lvl, hi_lvl, pos, mileage;
		int s[NS];
		full = int'(full_scale_r);
		sp = (full * (NS - 1)) / 2;
		below = (on_track_r > 0) ? int'(on_track_r) - 1 : 0;
		lo_lvl = (full * int'(ltsc_pkg::PCT_LOW)) / int'(ltsc_pkg::PCT_BASE);
		hi_lvl = (full * int'(ltsc_pkg::PCT_HIGH)) / int'(ltsc_pkg::PCT_BASE);
		foreach (s[i])
			s[i] = 0;
		pos = pick(sp - full / 4, sp + full / 4);
		case (kind)
			SK_CENTER, SK_SHARP_L, SK_SHARP_R: begin
				s[2] = pick(hi_lvl, full);
				s[1] = pick(0, full / 2);
				s[3] = pick(0, full / 2);
				s[0] = pick(0, below);
				s[4] = pick(0, below);
				if (kind == SK_SHARP_L)
					pos = pick(0, sp - int'(sharp_r));
				else if (kind == SK_SHARP_R)
					pos = pick(sp + int'(sharp_r), POS_LIMIT);
			end
			SK_INNER_L: begin
				s[1] = pick(full / 2, full);
				s[2] = pick(0, full / 4);
				s[0] = pick(0, full);
				pos = pick(0, sp);
			end
			SK_INNER_R: begin
				s[3] = pick(full / 2, full);
				s[2] = pick(0, full / 4);
				s[4] = pick(0, full);
				pos = pick(sp, 2 * sp);
			end
			SK_LINE: begin
				s[0] = pick(lo_lvl, full);
				s[4] = pick(lo_lvl, full);
				s[2] = pick(hi_lvl, full);
				s[1] = pick(0, hi_lvl - 1);
				s[3] = pick(0, hi_lvl - 1);
				pos = pick(sp - full / 2, sp + full / 2);
			end
			SK_GAP: begin
				if (pick(0, 2) != 0)
					foreach (s[i])
						s[i] = pick(0, below);
				pos = pick(0, POS_LIMIT);
			end
			SK_OFF_LEFT: begin
				s[0] = pick(int'(on_track_r), full);
				s[1] = pick(0, full / 8);
				pos = pick(0, full / 2);
			end
			default: begin
				foreach (s[i])
					s[i] = int'($urandom_range(4095));
				pos = int'($urandom_range(POS_LIMIT));
			end
		endcase
		if (pos > POS_LIMIT)
			pos = POS_LIMIT;
		if (pos < 0)
			pos = 0;
		if (pick(0, 3) == 0)
			mileage = int'($urandom_range(65535));
		else
			mileage = pick(0, int'(max_lost_r));
		return sample_of(pos, s[0], s[1], s[2], s[3], s[4], mileage, pick(0, 49) == 0);
	endfunction

	task automatic send_kind(sample_kind_t kind);
		send_sample(pick(0, 59) == 0, make_sample(kind));
	endtask

	// Drive one lap: start, then random track segments
	task automatic run_lap();
		send_sample(1'b1, make_sample(SK_CENTER));
		repeat (pick(4, 10)) begin
			case (pick(0, 7))
				0: repeat (pick(1, 3)) send_kind(SK_CENTER);
				1: begin
					repeat (pick(1, 3)) send_kind(SK_LINE);
					send_kind(SK_CENTER);
				end
				2: begin
					send_kind(SK_SHARP_L);
					repeat (pick(0, 1)) send_kind(SK_CENTER);
					repeat (pick(1, 3)) send_kind(SK_INNER_R);
					send_kind(SK_CENTER);
				end
				3: begin
					send_kind(SK_SHARP_R);
					repeat (pick(0, 1)) send_kind(SK_CENTER);
					repeat (pick(1, 3)) send_kind(SK_INNER_L);
					send_kind(SK_CENTER);
				end
				4: begin
					repeat (pick(1, 4)) send_kind(SK_GAP);
					send_kind(SK_CENTER);
				end
				5: begin
					send_kind(SK_OFF_LEFT);
					repeat (pick(1, 3)) send_kind(SK_GAP);
					send_kind(SK_CENTER);
				end
				6: repeat (pick(1, 2)) send_kind(SK_NOISE);
				default: send_sample(1'b1, make_sample(SK_CENTER));
			endcase
		end
	endtask

	// Walk every status, line, lost and abort case at the reset registers
	task automatic test_directed_cases();
		send_sample(1'b0, sample_of(2000, 0, 500, 1000, 500, 0, 0, 1'b0));
		send_sample(1'b0, sample_of(2000, 1000, 100, 1000, 100, 1000, 0, 1'b0));
		// stay on the line while the outer sensors still see it
		send_sample(1'b0, sample_of(2000, 1000, 100, 1000, 100, 1000, 0, 1'b0));
		send_sample(1'b0, sample_of(2000, 0, 500, 1000, 500, 0, 0, 1'b0));
		// sharp left, turn, back to normal
		send_sample(1'b0, sample_of(500, 0, 500, 1000, 500, 0, 0, 1'b0));
		send_sample(1'b0, sample_of(2000, 0, 0, 100, 1000, 0, 0, 1'b0));
		send_sample(1'b0, sample_of(2000, 0, 0, 100, 1000, 0, 0, 1'b0));
		send_sample(1'b0, sample_of(2000, 0, 500, 1000, 500, 0, 0, 1'b0));
		// sharp right, turn, back to normal
		send_sample(1'b0, sample_of(3500, 0, 500, 1000, 500, 0, 0, 1'b0));
		send_sample(1'b0, sample_of(2000, 0, 1000, 100, 0, 0, 0, 1'b0));
		send_sample(1'b0, sample_of(2000, 0, 500, 1000, 500, 0, 0, 1'b0));
		// gap with dark inner sensors, then abort on lost distance
		send_sample(1'b0, sample_of(2000, 0, 0, 0, 0, 0, 50, 1'b0));
		send_sample(1'b0, sample_of(2000, 0, 0, 0, 0, 0, 201, 1'b0));
		// stop line after finish, twice
		send_sample(1'b0, sample_of(2000, 1000, 100, 1000, 100, 1000, 0, 1'b0));
		send_sample(1'b0, sample_of(2000, 1000, 100, 1000, 100, 1000, 0, 1'b0));
		// re-arm, then lose the track off-center and find it again
		send_sample(1'b1, sample_of(2000, 0, 500, 1000, 500, 0, 0, 1'b0));
		send_sample(1'b0, sample_of(100, 1000, 0, 0, 0, 0, 0, 1'b0));
		send_sample(1'b0, sample_of(100, 0, 0, 0, 0, 0, 200, 1'b0));
		send_sample(1'b0, sample_of(2000, 0, 500, 1000, 500, 0, 0, 1'b0));
		// observation timeout, also while finished
		send_sample(1'b0, sample_of(2000, 0, 500, 1000, 500, 0, 0, 1'b1));
		send_sample(1'b0, sample_of(2000, 1000, 100, 1000, 100, 1000, 0, 1'b1));
		// field extremes
		send_sample(1'b1, sample_of(POS_LIMIT, 4095, 4095, 4095, 4095, 4095, 65535, 1'b0));
		send_sample(1'b1, sample_of(0, 0, 0, 0, 0, 0, 0, 1'b0));
		send_sample(1'b0, sample_of(POS_LIMIT, 0, 0, 0, 0, 4095, 65535, 1'b1));
	endtask

	// Random laps over four register settings at one flow-control mix
	task automatic test_random_laps(int phase, int send_pct, int recv_pct);
		int first;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int k = 0; k < 4; k++) begin
			apply_setting((k < 2) ? (2 * phase + k) % 4 : 4);
			first = items_sent;
			while (items_sent - first < SETTING_ITEMS)
				run_lap();
		end
	endtask

	initial begin
		send_idle_pct = 17;
		recv_idle_pct = 53;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_laps(0, 17, 53);
		test_random_laps(1, 53, 17);
		test_random_laps(2, 0, 0);
		wait_drained();

		$display("Sent %0d samples over %0d register settings and three flow-control mixes",
			items_sent, settings_done);
		$display("Checked %0d result items, %0d field mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/ltsc_pkg.sv
hw/rtl/ltsc_centroid.sv
hw/rtl/ltsc_classify.sv
hw/rtl/line_track_status_classifier_core.sv
verif/line_track_status_classifier_core_test.sv
